>>> rtl/rtc_alarm_snooze_controller_unit_assert.svh
// Assertion macros used by the alarm clock state logic in rasc_core.
// Expects clk and rst_n in the scope of the file that includes it.
`ifndef RTC_ALARM_SNOOZE_CONTROLLER_UNIT_ASSERT_SVH
`define RTC_ALARM_SNOOZE_CONTROLLER_UNIT_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define RASC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define RASC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/rasc_pkg.sv
// Shared types, constants and helper functions of the alarm clock core.
// No dependencies; used by every module under rtl.
package rasc_pkg;

  localparam logic [16:0] DAY_SECS  = 17'd86400;
  localparam logic [16:0] TOD_MAX   = 17'd86399;
  localparam logic [16:0] HOUR_SECS = 17'd3600;
  localparam logic [16:0] MIN_SECS  = 17'h003C;
  localparam logic [4:0]  HOUR_MAX  = 5'd23;
  localparam logic [5:0]  MIN_MAX   = 6'd59;
  localparam logic [5:0]  SEC_MAX   = 6'd59;

  localparam logic [3:0] LED_NONE = 4'h0;
  localparam logic [3:0] LED_D9   = 4'h1;
  localparam logic [3:0] LED_D10  = 4'h2;
  localparam logic [3:0] LED_D11  = 4'h4;
  localparam logic [3:0] LED_D12  = 4'h8;

  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [2:0] {
    REQ_SEC_TICK   = 3'd0,
    REQ_LIGHT_TICK = 3'd1,
    REQ_BUTTON     = 3'd2,
    REQ_SET_TIME   = 3'd3,
    REQ_ARM        = 3'd4
  } req_type_t;

  typedef enum logic [2:0] {
    CFG_ALARM_TOD      = 3'd0,
    CFG_RETRY_LIMIT    = 3'd1,
    CFG_RETRY_INTERVAL = 3'd2,
    CFG_LIGHT_MODE     = 3'd3,
    CFG_SOUND_MODE     = 3'd4,
    CFG_RING_SECONDS   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LIGHT_NONE    = 2'd0,
    LIGHT_FORWARD = 2'd1,
    LIGHT_REVERSE = 2'd2,
    LIGHT_PAIRS   = 2'd3
  } light_mode_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] set_hour;
    logic [5:0] set_minute;
    logic [5:0] set_second;
  } item_t;

  typedef struct packed {
    logic [16:0] alarm_time_of_day;
    logic [2:0]  retry_limit;
    logic [16:0] retry_interval;
    logic [1:0]  light_mode;
    logic [1:0]  sound_mode;
    logic [7:0]  ring_seconds;
  } cfg_t;

  typedef struct packed {
    logic [4:0] cur_hour;
    logic [5:0] cur_minute;
    logic [5:0] cur_second;
    logic       armed;
    logic       ringing;
    logic [3:0] led_on;
    logic       sound_on;
    logic [1:0] sound_pattern;
    logic [2:0] retries_used;
    logic       set_error;
  } result_t;

  // Next LED pattern on a light tick.
  function automatic logic [3:0] light_next(input logic [1:0] mode, input logic [3:0] s);
    logic [3:0] n;
    n = LED_NONE;
    case (light_mode_t'(mode))
      LIGHT_FORWARD: begin
        if (s == LED_NONE)     n = LED_D9;
        else if (s == LED_D9)  n = LED_D10;
        else if (s == LED_D10) n = LED_D11;
        else if (s == LED_D11) n = LED_D12;
        else if (s == LED_D12) n = LED_D9;
      end
      LIGHT_REVERSE: begin
        if (s == LED_NONE)     n = LED_D12;
        else if (s == LED_D12) n = LED_D11;
        else if (s == LED_D11) n = LED_D10;
        else if (s == LED_D10) n = LED_D9;
        else if (s == LED_D9)  n = LED_D12;
      end
      LIGHT_PAIRS: begin
        if (s == LED_NONE)               n = LED_D10 | LED_D11;
        else if (s == (LED_D10 | LED_D11)) n = LED_D9 | LED_D12;
      end
      default: n = LED_NONE;
    endcase
    return n;
  endfunction

  // Next occurrence of the alarm time of day, given the counter split into
  // day start and time of day. Wraps at 32 bits like the counter.
  function automatic logic [31:0] alarm_schedule(input logic [31:0] day_base,
                                                 input logic [16:0] tod,
                                                 input logic [16:0] alarm_tod);
    logic [16:0] atod_m;
    logic [31:0] day_add;
    atod_m  = (alarm_tod >= DAY_SECS) ? (alarm_tod - DAY_SECS) : alarm_tod;
    day_add = (atod_m < tod) ? 32'(DAY_SECS) : 32'd0;
    return day_base + 32'(atod_m) + day_add;
  endfunction

endpackage

>>> rtl/rtc_alarm_snooze_controller_unit.sv
// Alarm clock core with snooze, top level: configuration registers and the
// input stage, state update and result stage. Depends on rasc_pkg,
// rasc_in_stage, rasc_core and rasc_out_stage.
//
// Every transaction on the in_ channel (second tick, light tick, button,
// set time, arm) produces exactly one status transaction on the out_ channel.
// A transaction is captured in the input register, applied to the clock state
// by combinational logic once the result register has space, and the resulting
// status is held in the result register, which drives out_valid; the block
// takes one transaction per cycle as long as out_ready keeps up. The seconds
// counter is carried alongside its day start, time of day and h/m/s fields,
// so each step is an increment with carries or one 32-bit add and compare; no
// division appears in the datapath. Write configuration registers only while
// no transaction is in flight.
module rtc_alarm_snooze_controller_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rasc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rasc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_req_type,
  input  logic [5:0]                         in_set_hour,
  input  logic [5:0]                         in_set_minute,
  input  logic [5:0]                         in_set_second,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [4:0]                         out_cur_hour,
  output logic [5:0]                         out_cur_minute,
  output logic [5:0]                         out_cur_second,
  output logic                               out_armed,
  output logic                               out_ringing,
  output logic [3:0]                         out_led_on,
  output logic                               out_sound_on,
  output logic [1:0]                         out_sound_pattern,
  output logic [2:0]                         out_retries_used,
  output logic                               out_set_error
);

  rasc_pkg::cfg_t    cfg_r;
  rasc_pkg::item_t   item;
  rasc_pkg::result_t res;
  logic              item_valid;
  logic              out_space;
  logic              fire;

  // Apply a transaction when one is held and the result register can take it.
  assign fire = item_valid && out_space;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_time_of_day <= 17'd0;
      cfg_r.retry_limit       <= 3'd2;
      cfg_r.retry_interval    <= 17'd600;
      cfg_r.light_mode        <= 2'd1;
      cfg_r.sound_mode        <= 2'd1;
      cfg_r.ring_seconds      <= 8'd7;
    end else if (cfg_wr_en) begin
      case (rasc_pkg::cfg_idx_t'(cfg_index))
        rasc_pkg::CFG_ALARM_TOD:      cfg_r.alarm_time_of_day <= cfg_wdata[16:0];
        rasc_pkg::CFG_RETRY_LIMIT:    cfg_r.retry_limit       <= cfg_wdata[2:0];
        rasc_pkg::CFG_RETRY_INTERVAL: cfg_r.retry_interval    <= cfg_wdata[16:0];
        rasc_pkg::CFG_LIGHT_MODE:     cfg_r.light_mode        <= cfg_wdata[1:0];
        rasc_pkg::CFG_SOUND_MODE:     cfg_r.sound_mode        <= cfg_wdata[1:0];
        rasc_pkg::CFG_RING_SECONDS:   cfg_r.ring_seconds      <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the incoming transaction until the update stage consumes it.
  rasc_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_set_hour   (in_set_hour),
    .in_set_minute (in_set_minute),
    .in_set_second (in_set_second),
    .take_i        (fire),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  // Advance the clock, alarm and LED state; form the status.
  rasc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg_r),
    .fire_i (fire),
    .item_i (item),
    .res_o  (res)
  );

  // Hold the status until the consumer takes it.
  rasc_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_i            (fire),
    .res_i             (res),
    .space_o           (out_space),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cur_hour      (out_cur_hour),
    .out_cur_minute    (out_cur_minute),
    .out_cur_second    (out_cur_second),
    .out_armed         (out_armed),
    .out_ringing       (out_ringing),
    .out_led_on        (out_led_on),
    .out_sound_on      (out_sound_on),
    .out_sound_pattern (out_sound_pattern),
    .out_retries_used  (out_retries_used),
    .out_set_error     (out_set_error)
  );

endmodule

>>> rtl/rasc_in_stage.sv
// Input register of the alarm clock core: captures one transaction per cycle while the held one is taken.
// Depends on rasc_pkg.
module rasc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_req_type,
  input  logic [5:0]          in_set_hour,
  input  logic [5:0]          in_set_minute,
  input  logic [5:0]          in_set_second,
  input  logic                take_i,
  output logic                item_valid_o,
  output rasc_pkg::item_t     item_o
);

  logic            valid_r;
  rasc_pkg::item_t item_r;

  assign in_ready     = !valid_r || take_i;
  assign item_valid_o = valid_r;
  assign item_o       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= '{req_type: in_req_type, set_hour: in_set_hour,
                  set_minute: in_set_minute, set_second: in_set_second};
    end
  end

endmodule

>>> rtl/rasc_core.sv
// Alarm clock state and per-transaction update logic.
// Depends on rasc_pkg and rtc_alarm_snooze_controller_unit_assert.svh.
`include "rtc_alarm_snooze_controller_unit_assert.svh"

module rasc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  rasc_pkg::cfg_t      cfg_i,
  input  logic                fire_i,
  input  rasc_pkg::item_t     item_i,
  output rasc_pkg::result_t   res_o
);

  // Counter kept in split form too: day start, time of day, and h/m/s.
  logic [31:0] count_r,  count_nxt;
  logic [31:0] base_r,   base_nxt;
  logic [16:0] tod_r,    tod_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  min_r,    min_nxt;
  logic [5:0]  sec_r,    sec_nxt;
  logic [31:0] target_r, target_nxt;
  logic        tvalid_r, tvalid_nxt;
  logic        standby_r, standby_nxt;
  logic        ring_r,   ring_nxt;
  logic [7:0]  rtimer_r, rtimer_nxt;
  logic [2:0]  attempt_r, attempt_nxt;
  logic [3:0]  led_r,    led_nxt;
  logic        err;

  logic [16:0] set_tod;
  logic        set_bad;
  logic [16:0] hms_tod;

  assign set_tod = 17'(item_i.set_hour) * rasc_pkg::HOUR_SECS
                 + 17'(item_i.set_minute) * rasc_pkg::MIN_SECS
                 + 17'(item_i.set_second);
  assign set_bad = (item_i.set_hour >= 6'd24) || (item_i.set_minute > rasc_pkg::MIN_MAX)
                || (item_i.set_second > rasc_pkg::SEC_MAX);

  // Time of day rebuilt from the h/m/s registers, checked against tod_r.
  assign hms_tod = 17'(hour_r) * rasc_pkg::HOUR_SECS + 17'(min_r) * rasc_pkg::MIN_SECS
                 + 17'(sec_r);

  always_comb begin
    count_nxt   = count_r;
    base_nxt    = base_r;
    tod_nxt     = tod_r;
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    target_nxt  = target_r;
    tvalid_nxt  = tvalid_r;
    standby_nxt = standby_r;
    ring_nxt    = ring_r;
    rtimer_nxt  = rtimer_r;
    attempt_nxt = attempt_r;
    led_nxt     = led_r;
    err         = 1'b0;

    case (rasc_pkg::req_type_t'(item_i.req_type))
      rasc_pkg::REQ_SEC_TICK: begin
        count_nxt = count_r + 32'd1;
        // Advance split forms; counter wrap at 2^32 lands on midnight of day 0.
        if (&count_r) begin
          base_nxt = 32'd0;
          tod_nxt  = 17'd0;
          hour_nxt = 5'd0;
          min_nxt  = 6'd0;
          sec_nxt  = 6'd0;
        end else begin
          if (tod_r == rasc_pkg::TOD_MAX) begin
            tod_nxt  = 17'd0;
            base_nxt = base_r + 32'(rasc_pkg::DAY_SECS);
          end else begin
            tod_nxt = tod_r + 17'd1;
          end
          if (sec_r == rasc_pkg::SEC_MAX) begin
            sec_nxt = 6'd0;
            if (min_r == rasc_pkg::MIN_MAX) begin
              min_nxt  = 6'd0;
              hour_nxt = (hour_r == rasc_pkg::HOUR_MAX) ? 5'd0 : hour_r + 5'd1;
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
        end
        if (ring_r) begin
          rtimer_nxt = rtimer_r - 8'd1;
          if (rtimer_nxt == 8'd0) begin
            ring_nxt = 1'b0;
            led_nxt  = rasc_pkg::LED_NONE;
            if (attempt_r < cfg_i.retry_limit) begin
              target_nxt  = count_nxt + 32'(cfg_i.retry_interval);
              tvalid_nxt  = 1'b1;
              led_nxt     = rasc_pkg::LED_D12;
              attempt_nxt = attempt_r + 3'd1;
            end else begin
              attempt_nxt = 3'd0;
              standby_nxt = 1'b0;
            end
          end
        end
        if (standby_nxt && !ring_nxt && tvalid_nxt && (count_nxt == target_nxt)) begin
          ring_nxt   = 1'b1;
          tvalid_nxt = 1'b0;
          rtimer_nxt = (cfg_i.ring_seconds == 8'd0) ? 8'd1 : cfg_i.ring_seconds;
        end
      end
      rasc_pkg::REQ_LIGHT_TICK: begin
        if (ring_r) begin
          led_nxt = rasc_pkg::light_next(cfg_i.light_mode, led_r);
        end
      end
      rasc_pkg::REQ_BUTTON: begin
        if (standby_r) begin
          ring_nxt    = 1'b0;
          rtimer_nxt  = 8'd0;
          led_nxt     = rasc_pkg::LED_NONE;
          attempt_nxt = 3'd0;
          standby_nxt = 1'b0;
        end else begin
          attempt_nxt = 3'd0;
          standby_nxt = 1'b1;
          target_nxt  = rasc_pkg::alarm_schedule(base_r, tod_r, cfg_i.alarm_time_of_day);
          tvalid_nxt  = 1'b1;
          led_nxt     = led_r | rasc_pkg::LED_D12;
        end
      end
      rasc_pkg::REQ_SET_TIME: begin
        if (set_bad) begin
          err = 1'b1;
        end else begin
          count_nxt  = 32'(set_tod);
          base_nxt   = 32'd0;
          tod_nxt    = set_tod;
          hour_nxt   = item_i.set_hour[4:0];
          min_nxt    = item_i.set_minute;
          sec_nxt    = item_i.set_second;
          target_nxt = rasc_pkg::alarm_schedule(32'd0, set_tod, cfg_i.alarm_time_of_day);
          tvalid_nxt = 1'b1;
        end
      end
      rasc_pkg::REQ_ARM: begin
        attempt_nxt = 3'd0;
        standby_nxt = 1'b1;
        target_nxt  = rasc_pkg::alarm_schedule(base_r, tod_r, cfg_i.alarm_time_of_day);
        tvalid_nxt  = 1'b1;
        led_nxt     = led_r | rasc_pkg::LED_D12;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 32'd0;
      base_r    <= 32'd0;
      tod_r     <= 17'd0;
      hour_r    <= 5'd0;
      min_r     <= 6'd0;
      sec_r     <= 6'd0;
      target_r  <= 32'd0;
      tvalid_r  <= 1'b0;
      standby_r <= 1'b0;
      ring_r    <= 1'b0;
      rtimer_r  <= 8'd0;
      attempt_r <= 3'd0;
      led_r     <= rasc_pkg::LED_NONE;
    end else if (fire_i) begin
      count_r   <= count_nxt;
      base_r    <= base_nxt;
      tod_r     <= tod_nxt;
      hour_r    <= hour_nxt;
      min_r     <= min_nxt;
      sec_r     <= sec_nxt;
      target_r  <= target_nxt;
      tvalid_r  <= tvalid_nxt;
      standby_r <= standby_nxt;
      ring_r    <= ring_nxt;
      rtimer_r  <= rtimer_nxt;
      attempt_r <= attempt_nxt;
      led_r     <= led_nxt;
    end
  end

  assign res_o = '{cur_hour: hour_nxt, cur_minute: min_nxt, cur_second: sec_nxt,
                   armed: standby_nxt, ringing: ring_nxt, led_on: led_nxt,
                   sound_on: ring_nxt && (cfg_i.sound_mode != 2'd0),
                   sound_pattern: cfg_i.sound_mode, retries_used: attempt_nxt,
                   set_error: err};

  // Arming or setting the time while ringing schedules a new target, so ringing
  // implies only the armed state and a running ring timer.
  `RASC_ASSERT_ALWAYS(a_split_sum, (base_r + 32'(tod_r)) == count_r, "counter split")
  `RASC_ASSERT_ALWAYS(a_hms_tod, hms_tod == tod_r, "h/m/s disagree with time of day")
  `RASC_ASSERT_IMPLY(a_ring_timer, ring_r, rtimer_r != 8'd0, "ringing with an expired timer")
  `RASC_ASSERT_IMPLY(a_ring_armed, ring_r, standby_r, "ringing while disarmed")

endmodule

>>> rtl/rasc_out_stage.sv
// Result register of the alarm clock core, drives the result channel.
// Depends on rasc_pkg.
module rasc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_i,
  input  rasc_pkg::result_t   res_i,
  output logic                space_o,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          out_cur_hour,
  output logic [5:0]          out_cur_minute,
  output logic [5:0]          out_cur_second,
  output logic                out_armed,
  output logic                out_ringing,
  output logic [3:0]          out_led_on,
  output logic                out_sound_on,
  output logic [1:0]          out_sound_pattern,
  output logic [2:0]          out_retries_used,
  output logic                out_set_error
);

  logic              valid_r;
  rasc_pkg::result_t res_r;

  assign space_o = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (space_o) begin
      valid_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid         = valid_r;
  assign out_cur_hour      = res_r.cur_hour;
  assign out_cur_minute    = res_r.cur_minute;
  assign out_cur_second    = res_r.cur_second;
  assign out_armed         = res_r.armed;
  assign out_ringing       = res_r.ringing;
  assign out_led_on        = res_r.led_on;
  assign out_sound_on      = res_r.sound_on;
  assign out_sound_pattern = res_r.sound_pattern;
  assign out_retries_used  = res_r.retries_used;
  assign out_set_error     = res_r.set_error;

endmodule

>>> bench/rtc_alarm_snooze_controller_unit_tb.sv
// Self-checking bench for the alarm clock core: drives request transactions,
// predicts every status transaction and compares it field by field.
// Depends on rasc_pkg and rtc_alarm_snooze_controller_unit under rtl.
module rtc_alarm_snooze_controller_unit_tb;
  import rasc_pkg::*;

  // Request codes the block must ignore (reported, no state change).
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_req_type = '0;
  logic [5:0]            in_set_hour = '0;
  logic [5:0]            in_set_minute = '0;
  logic [5:0]            in_set_second = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [4:0]            out_cur_hour;
  logic [5:0]            out_cur_minute;
  logic [5:0]            out_cur_second;
  logic                  out_armed;
  logic                  out_ringing;
  logic [3:0]            out_led_on;
  logic                  out_sound_on;
  logic [1:0]            out_sound_pattern;
  logic [2:0]            out_retries_used;
  logic                  out_set_error;

  rtc_alarm_snooze_controller_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_set_hour       (in_set_hour),
    .in_set_minute     (in_set_minute),
    .in_set_second     (in_set_second),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cur_hour      (out_cur_hour),
    .out_cur_minute    (out_cur_minute),
    .out_cur_second    (out_cur_second),
    .out_armed         (out_armed),
    .out_ringing       (out_ringing),
    .out_led_on        (out_led_on),
    .out_sound_on      (out_sound_on),
    .out_sound_pattern (out_sound_pattern),
    .out_retries_used  (out_retries_used),
    .out_set_error     (out_set_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Clock model: a private copy of the register file and of the alarm state,
  // stepped once per accepted request transaction.
  // ---------------------------------------------------------------------------
  cfg_t        live_cfg;
  logic [31:0] clk_secs;
  logic [31:0] wake_at;
  logic        wake_set;
  logic        standby_on;
  logic        ring_on;
  logic [7:0]  ring_left;
  logic [2:0]  snoozes;
  logic [3:0]  led_bits;

  result_t     status_queue[$];
  int          mismatch_count = 0;
  int          burst_left = 0;

  // Next occurrence of the alarm time of day at or after the counter.
  function automatic logic [31:0] next_wake();
    logic [63:0] cur;
    logic [63:0] t;
    cur = 64'(clk_secs);
    t = (cur / 64'(DAY_SECS)) * 64'(DAY_SECS) + 64'(live_cfg.alarm_time_of_day % DAY_SECS);
    if (t < cur) t = t + 64'(DAY_SECS);
    return t[31:0];
  endfunction

  task automatic arm_alarm();
    snoozes    = '0;
    standby_on = 1'b1;
    wake_at    = next_wake();
    wake_set   = 1'b1;
    led_bits   = led_bits | LED_D12;
  endtask

  task automatic disarm_alarm();
    snoozes    = '0;
    standby_on = 1'b0;
    led_bits   = led_bits & ~LED_D12;
  endtask

  task automatic silence();
    ring_on   = 1'b0;
    ring_left = '0;
    led_bits  = LED_NONE;
  endtask

  task automatic advance_second();
    clk_secs = clk_secs + 32'd1;
    if (ring_on) begin
      ring_left = ring_left - 8'd1;
      if (ring_left == 8'd0) begin
        silence();
        // Snooze: reschedule while attempts remain, otherwise drop the alarm.
        if (snoozes < live_cfg.retry_limit) begin
          wake_at  = clk_secs + 32'(live_cfg.retry_interval);
          wake_set = 1'b1;
          led_bits = led_bits | LED_D12;
          snoozes  = snoozes + 3'd1;
        end else begin
          disarm_alarm();
        end
      end
    end
    // Match is tested after the increment, so a zero interval rings again here.
    if (standby_on && !ring_on && wake_set && clk_secs == wake_at) begin
      ring_on   = 1'b1;
      wake_set  = 1'b0;
      ring_left = (live_cfg.ring_seconds == 8'd0) ? 8'd1 : live_cfg.ring_seconds;
    end
  endtask

  task automatic predict_status(input item_t it, output result_t r);
    logic        bad_set;
    logic [31:0] tod;
    bad_set = 1'b0;
    case (it.req_type)
      REQ_SEC_TICK: advance_second();
      REQ_LIGHT_TICK: begin
        if (ring_on) begin
          case (live_cfg.light_mode)
            LIGHT_FORWARD: begin
              case (led_bits)
                LED_NONE: led_bits = LED_D9;
                LED_D9:   led_bits = LED_D10;
                LED_D10:  led_bits = LED_D11;
                LED_D11:  led_bits = LED_D12;
                LED_D12:  led_bits = LED_D9;
                default:  led_bits = LED_NONE;
              endcase
            end
            LIGHT_REVERSE: begin
              case (led_bits)
                LED_NONE: led_bits = LED_D12;
                LED_D12:  led_bits = LED_D11;
                LED_D11:  led_bits = LED_D10;
                LED_D10:  led_bits = LED_D9;
                LED_D9:   led_bits = LED_D12;
                default:  led_bits = LED_NONE;
              endcase
            end
            LIGHT_PAIRS: begin
              if (led_bits == LED_NONE) led_bits = LED_D10 | LED_D11;
              else if (led_bits == (LED_D10 | LED_D11)) led_bits = LED_D9 | LED_D12;
              else led_bits = LED_NONE;
            end
            default: led_bits = LED_NONE;
          endcase
        end
      end
      REQ_BUTTON: begin
        if (standby_on) begin
          silence();
          disarm_alarm();
        end else begin
          arm_alarm();
        end
      end
      REQ_SET_TIME: begin
        if (it.set_hour > 6'(HOUR_MAX) || it.set_minute > MIN_MAX || it.set_second > SEC_MAX) begin
          bad_set = 1'b1;
        end else begin
          clk_secs = 32'(it.set_hour) * 32'(HOUR_SECS) + 32'(it.set_minute) * 32'(MIN_SECS)
                   + 32'(it.set_second);
          wake_at  = next_wake();
          wake_set = 1'b1;
        end
      end
      REQ_ARM: arm_alarm();
      default: ;
    endcase
    tod = clk_secs % 32'(DAY_SECS);
    r.cur_hour      = 5'(tod / 32'(HOUR_SECS));
    r.cur_minute    = 6'((tod % 32'(HOUR_SECS)) / 32'(MIN_SECS));
    r.cur_second    = 6'(tod % 32'(MIN_SECS));
    r.armed         = standby_on;
    r.ringing       = ring_on;
    r.led_on        = led_bits;
    r.sound_on      = ring_on && (live_cfg.sound_mode != 2'd0);
    r.sound_pattern = live_cfg.sound_mode;
    r.retries_used  = snoozes;
    r.set_error     = bad_set;
  endtask

  function automatic logic [5:0] rnd6();
    return 6'($urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Valid is raised at a clock edge and held with a stable
  // payload until accepted; the sender runs in bursts with random gaps.
  // Valid is only lowered at the start of a gap or when draining, never in the
  // same step where it is raised again.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] kind, input logic [5:0] hh,
                          input logic [5:0] mm, input logic [5:0] ss);
    item_t   it;
    result_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left = burst_left - 1;
    it.req_type   = kind;
    it.set_hour   = hh;
    it.set_minute = mm;
    it.set_second = ss;
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_set_hour   <= hh;
    in_set_minute <= mm;
    in_set_second <= ss;
    do @(posedge clk); while (!in_ready);
    predict_status(it, r);
    status_queue.push_back(r);
  endtask

  // Drop valid and hold until every status transaction is back and the
  // two-stage pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [16:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Drain, then write all six registers back to back.
  task automatic apply_settings(input cfg_t c);
    drain();
    live_cfg = c;
    put_reg(CFG_ALARM_TOD, c.alarm_time_of_day);
    put_reg(CFG_RETRY_LIMIT, 17'(c.retry_limit));
    put_reg(CFG_RETRY_INTERVAL, c.retry_interval);
    put_reg(CFG_LIGHT_MODE, 17'(c.light_mode));
    put_reg(CFG_SOUND_MODE, 17'(c.sound_mode));
    put_reg(CFG_RING_SECONDS, 17'(c.ring_seconds));
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Status side: out_ready steps through four patterns picked by a free-running counter:
  // always ready, coin flip, mostly stalled, and a regular on/off comb.
  // ---------------------------------------------------------------------------
  logic [9:0] stall_cycle = '0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_cycle[4] | stall_cycle[1];
    endcase
  end

  function automatic string status_text(input result_t r);
    return $sformatf("%0d:%0d:%0d armed=%0b ring=%0b led=%h snd=%0b pat=%0d retry=%0d err=%0b",
                     r.cur_hour, r.cur_minute, r.cur_second, r.armed, r.ringing, r.led_on,
                     r.sound_on, r.sound_pattern, r.retries_used, r.set_error);
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t seen);
    mismatch_count = mismatch_count + 1;
    if (mismatch_count <= 10)
      $display("MISMATCH %0s at %0t: expected %0s, got %0s", what, $time,
               status_text(want), status_text(seen));
  endtask

  // Compare each accepted status transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.cur_hour      = out_cur_hour;
      seen.cur_minute    = out_cur_minute;
      seen.cur_second    = out_cur_second;
      seen.armed         = out_armed;
      seen.ringing       = out_ringing;
      seen.led_on        = out_led_on;
      seen.sound_on      = out_sound_on;
      seen.sound_pattern = out_sound_pattern;
      seen.retries_used  = out_retries_used;
      seen.set_error     = out_set_error;
      if (status_queue.size() == 0) begin
        report_mismatch("unexpected status", '0, seen);
      end else begin
        want = status_queue.pop_front();
        if (seen.cur_hour !== want.cur_hour || seen.cur_minute !== want.cur_minute ||
            seen.cur_second !== want.cur_second || seen.armed !== want.armed ||
            seen.ringing !== want.ringing || seen.led_on !== want.led_on ||
            seen.sound_on !== want.sound_on || seen.sound_pattern !== want.sound_pattern ||
            seen.retries_used !== want.retries_used || seen.set_error !== want.set_error)
          report_mismatch("status fields", want, seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes of set time, midnight rollover, rejected fields, spare codes.
  task automatic test_time_fields();
    cfg_t c;
    c = '{alarm_time_of_day: 17'd0, retry_limit: 3'd2, retry_interval: 17'd600,
          light_mode: LIGHT_FORWARD, sound_mode: 2'd1, ring_seconds: 8'd7};
    apply_settings(c);
    send_req(REQ_SET_TIME, 6'd0, 6'd0, 6'd0);
    send_req(REQ_SET_TIME, 6'(HOUR_MAX), MIN_MAX, SEC_MAX);
    send_req(REQ_SEC_TICK, 6'd63, 6'd63, 6'd63);
    send_req(REQ_SET_TIME, 6'd24, 6'd0, 6'd0);
    send_req(REQ_SET_TIME, 6'd0, 6'd60, 6'd0);
    send_req(REQ_SET_TIME, 6'd0, 6'd0, 6'd60);
    send_req(REQ_SET_TIME, 6'd63, 6'd63, 6'd63);
    send_req(REQ_SPARE_FIRST, 6'd63, 6'd63, 6'd63);
    send_req(REQ_SPARE_LAST, 6'd0, 6'd0, 6'd0);
  endtask

  // Ring, pair light pattern, zero ring length and a zero retry interval that
  // restarts ringing on the very tick that ends it, then the final disarm.
  task automatic test_ring_and_snooze();
    cfg_t c;
    c = '{alarm_time_of_day: 17'd5, retry_limit: 3'd1, retry_interval: 17'd0,
          light_mode: LIGHT_PAIRS, sound_mode: 2'd3, ring_seconds: 8'd0};
    apply_settings(c);
    send_req(REQ_SET_TIME, 6'd0, 6'd0, 6'd4);
    send_req(REQ_ARM, rnd6(), rnd6(), rnd6());
    send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
    repeat (3) send_req(REQ_LIGHT_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_LIGHT_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
  endtask

  // Alarm time above the day length, a target equal to the counter (not hit),
  // silent ringing, reverse lights, arm while ringing and both button roles.
  task automatic test_alarm_edges();
    cfg_t c;
    c = '{alarm_time_of_day: 17'h1FFFF, retry_limit: 3'd5, retry_interval: TOD_MAX,
          light_mode: LIGHT_REVERSE, sound_mode: 2'd0, ring_seconds: 8'd255};
    apply_settings(c);
    send_req(REQ_SET_TIME, 6'd12, 6'd24, 6'd31);
    send_req(REQ_ARM, rnd6(), rnd6(), rnd6());
    send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_SET_TIME, 6'd12, 6'd24, 6'd30);
    send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_LIGHT_TICK, rnd6(), rnd6(), rnd6());
    send_req(REQ_ARM, rnd6(), rnd6(), rnd6());
    send_req(REQ_BUTTON, rnd6(), rnd6(), rnd6());
    send_req(REQ_BUTTON, rnd6(), rnd6(), rnd6());
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    case ($urandom_range(0, 5))
      0: c.alarm_time_of_day = 17'd0;
      1: c.alarm_time_of_day = TOD_MAX;
      2: c.alarm_time_of_day = 17'h1FFFF;
      3: c.alarm_time_of_day = 17'($urandom_range(86400, 131071));
      default: c.alarm_time_of_day = 17'($urandom_range(0, 86399));
    endcase
    c.retry_limit = 3'($urandom_range(0, 5));
    case ($urandom_range(0, 7))
      0: c.retry_interval = TOD_MAX;
      1: c.retry_interval = 17'($urandom_range(0, 86399));
      default: c.retry_interval = 17'($urandom_range(0, 15));
    endcase
    c.light_mode = 2'($urandom_range(0, 3));
    c.sound_mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: c.ring_seconds = 8'd0;
      1: c.ring_seconds = 8'd255;
      default: c.ring_seconds = 8'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  // Mostly well-formed phases: set the clock a few seconds short of the alarm,
  // arm, then tick and step lights through ringing and snoozes. One phase in
  // five is raw noise over every request code and field value.
  task automatic test_random_phases(input int phases, input int per_phase);
    int          pick;
    int unsigned lead;
    int unsigned start;
    bit          shaped;
    for (int p = 0; p < phases; p++) begin
      apply_settings(random_settings());
      shaped = ($urandom_range(0, 4) != 0);
      if (shaped) begin
        lead  = $urandom_range(1, 6);
        start = (32'(live_cfg.alarm_time_of_day % DAY_SECS) + 86400 - lead) % 86400;
        send_req(REQ_SET_TIME, 6'(start / 3600), 6'((start % 3600) / 60), 6'(start % 60));
        send_req(($urandom_range(0, 1) == 0) ? REQ_BUTTON : REQ_ARM, rnd6(), rnd6(), rnd6());
      end
      for (int n = 0; n < per_phase; n++) begin
        if (!shaped) begin
          send_req(3'($urandom_range(0, 7)), rnd6(), rnd6(), rnd6());
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 60)
            send_req(REQ_SEC_TICK, rnd6(), rnd6(), rnd6());
          else if (pick < 84)
            send_req(REQ_LIGHT_TICK, rnd6(), rnd6(), rnd6());
          else if (pick < 89)
            send_req(REQ_BUTTON, rnd6(), rnd6(), rnd6());
          else if (pick < 92)
            send_req(REQ_ARM, rnd6(), rnd6(), rnd6());
          else if (pick < 95)
            send_req(REQ_SET_TIME, 6'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                     6'($urandom_range(0, 59)));
          else if (pick < 98)
            send_req(REQ_SET_TIME, rnd6(), rnd6(), rnd6());
          else
            send_req(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)), rnd6(), rnd6(),
                     rnd6());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed tests, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    // Hold the model at its reset state to match the block coming out of reset.
    live_cfg   = '{alarm_time_of_day: 17'd0, retry_limit: 3'd2, retry_interval: 17'd600,
                   light_mode: LIGHT_FORWARD, sound_mode: 2'd1, ring_seconds: 8'd7};
    clk_secs   = '0;
    wake_at    = '0;
    wake_set   = 1'b0;
    standby_on = 1'b0;
    ring_on    = 1'b0;
    ring_left  = '0;
    snoozes    = '0;
    led_bits   = LED_NONE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_time_fields();
    test_ring_and_snooze();
    test_alarm_edges();
    test_random_phases(20, 95);

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about two thousand
  // transactions under full stalling.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
